>>> rtl/pbm_pkg.sv
// Package with the shared constants, mode codes and types of the pixel blend core.
`timescale 1ns / 1ps

package pbm_pkg;

	localparam int PIX_W   = 8;
	localparam int MODE_W  = 4;
	localparam int ALPHA_W = 9;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [MODE_W-1:0] MODE_MUL   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_MUL_A = 4'd1;
	localparam logic [MODE_W-1:0] MODE_SCR   = 4'd2;
	localparam logic [MODE_W-1:0] MODE_SCR_A = 4'd3;
	localparam logic [MODE_W-1:0] MODE_OVL   = 4'd4;
	localparam logic [MODE_W-1:0] MODE_OVL_A = 4'd5;
	localparam logic [MODE_W-1:0] MODE_HARD  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_DIV   = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ADD   = 4'd8;
	localparam logic [MODE_W-1:0] MODE_SUB   = 4'd9;
	localparam logic [MODE_W-1:0] MODE_DIFF  = 4'd10;
	localparam logic [MODE_W-1:0] MODE_MIN   = 4'd11;
	localparam logic [MODE_W-1:0] MODE_MAX   = 4'd12;
	localparam logic [MODE_W-1:0] MODE_GRAIN = 4'd13;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_ALPHA = 1'b1;

	localparam logic [MODE_W-1:0]  MODE_RESET = MODE_MUL;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;

	localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
	localparam logic [PIX_W-1:0] PIX_HALF = 8'd128;
	localparam logic [15:0] FULL_SCALE    = 16'd65280;
	localparam logic [15:0] RECIP_255     = 16'h8081;
	localparam int          RECIP_SHIFT   = 23;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ALPHA_W-1:0] alpha;
	} pbm_cfg_t;

endpackage

>>> rtl/pixel_blend_modes_core.sv
// Top level of the pixel blend core: five-stage blend pipeline with APB configuration.
// A word accepted into stage 1 passes stages 2 to 4; res_valid is the stage 5 valid bit.
// Throughput: one word per cycle while the output is not stalled; empty stages close up while it is.
// Division by 255 is a reciprocal multiply in stage 4; mask division runs over stages 1 to 4.
// Reset clears all stage valid bits and sets mode to multiply and alpha to one.
`timescale 1ns / 1ps

module pixel_blend_modes_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pbm_pkg::ADDR_W-1:0]  paddr,
	input  logic [pbm_pkg::DATA_W-1:0]  pwdata,
	output logic [pbm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic [pbm_pkg::PIX_W-1:0]   mask,
	input  logic [pbm_pkg::PIX_W-1:0]   image,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [pbm_pkg::PIX_W-1:0]   result
);

	pbm_pkg::pbm_cfg_t cfg;

	logic [5:1] en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [7:0]  m_s1, i_s1, m_s2, i_s2;
	logic [15:0] p1_s1, q1_s1, ma_s1, ia_s1;
	logic [15:0] p1_s2, q1_s2;
	logic [23:0] pa_s2, ya_s2, yb_s2;
	logic [15:0] n_s3;
	logic [7:0]  dir_s3, dir_s4;
	logic        sat_s3, sat_s4;
	logic [8:0]  q_s4;
	logic [7:0]  result_s5;
	logic [7:0]  quo;

	logic [15:0] n_d;
	logic [7:0]  dir_d;
	logic [23:0] scra_sum, ovla_sum;
	logic [8:0]  ovla_t;
	logic [8:0]  sum_mi, grain_g;
	logic [7:0]  blend_hi, blend_lo;
	logic [31:0] recip_prod;
	logic [7:0]  res_d;

	pbm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbm_div u_div (
		.clk      (clk),
		.adv      (en[4:1]),
		.dividend (image),
		.divisor  (mask),
		.quotient (quo)
	);

	// A stage moves when it is empty or the stage after it moves.
	assign en[5] = ~vld_s5 | res_ready;
	assign en[4] = ~vld_s4 | en[5];
	assign en[3] = ~vld_s3 | en[4];
	assign en[2] = ~vld_s2 | en[3];
	assign en[1] = ~vld_s1 | en[2];

	assign pix_ready = en[1];
	assign res_valid = vld_s5;
	assign result    = result_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en[1]) vld_s1 <= pix_valid;
			if (en[2]) vld_s2 <= vld_s1;
			if (en[3]) vld_s3 <= vld_s2;
			if (en[4]) vld_s4 <= vld_s3;
			if (en[5]) vld_s5 <= vld_s4;
		end
	end

	// Stage 3 operand selection and the modes that need no division by 255.
	always_comb begin
		scra_sum = ya_s2 + 24'd65279;
		ovla_sum = yb_s2 + 24'd32767;
		ovla_t   = ovla_sum[23:15];
		sum_mi   = 9'(m_s2) + 9'(i_s2);
		grain_g  = 9'(sum_mi - 9'(pbm_pkg::PIX_HALF));
		blend_hi = 8'(pbm_pkg::PIX_MAX - q1_s2[14:7]);
		blend_lo = p1_s2[14:7];

		unique case (cfg.mode)
			pbm_pkg::MODE_MUL:   n_d = p1_s2;
			pbm_pkg::MODE_MUL_A: n_d = pa_s2[23:8];
			pbm_pkg::MODE_SCR:   n_d = q1_s2 + 16'd254;
			pbm_pkg::MODE_SCR_A: n_d = scra_sum[23:8];
			default:             n_d = 16'd0;
		endcase

		unique case (cfg.mode)
			pbm_pkg::MODE_OVL: begin
				dir_d = (i_s2 > pbm_pkg::PIX_HALF) ? blend_hi : blend_lo;
			end
			pbm_pkg::MODE_OVL_A: begin
				if (i_s2 > pbm_pkg::PIX_HALF) begin
					dir_d = (ovla_t >= 9'(pbm_pkg::PIX_MAX)) ? 8'd0 :
						8'(9'(pbm_pkg::PIX_MAX) - ovla_t);
				end else begin
					dir_d = pa_s2[22:15];
				end
			end
			pbm_pkg::MODE_HARD: begin
				dir_d = (m_s2 < pbm_pkg::PIX_HALF) ? blend_lo : blend_hi;
			end
			pbm_pkg::MODE_ADD: begin
				dir_d = sum_mi[8] ? pbm_pkg::PIX_MAX : sum_mi[7:0];
			end
			pbm_pkg::MODE_SUB: begin
				dir_d = (i_s2 > m_s2) ? 8'(i_s2 - m_s2) : 8'd0;
			end
			pbm_pkg::MODE_DIFF: begin
				dir_d = (i_s2 >= m_s2) ? 8'(i_s2 - m_s2) : 8'(m_s2 - i_s2);
			end
			pbm_pkg::MODE_MIN: begin
				dir_d = (m_s2 < i_s2) ? m_s2 : i_s2;
			end
			pbm_pkg::MODE_MAX: begin
				dir_d = (m_s2 > i_s2) ? m_s2 : i_s2;
			end
			pbm_pkg::MODE_GRAIN: begin
				if (sum_mi < 9'(pbm_pkg::PIX_HALF)) begin
					dir_d = 8'd0;
				end else begin
					dir_d = grain_g[8] ? pbm_pkg::PIX_MAX : grain_g[7:0];
				end
			end
			default: begin
				dir_d = i_s2;
			end
		endcase
	end

	assign recip_prod = 32'(n_s3) * 32'(pbm_pkg::RECIP_255);

	always_comb begin
		unique case (cfg.mode)
			pbm_pkg::MODE_MUL, pbm_pkg::MODE_MUL_A: begin
				res_d = q_s4[8] ? pbm_pkg::PIX_MAX : q_s4[7:0];
			end
			pbm_pkg::MODE_SCR, pbm_pkg::MODE_SCR_A: begin
				res_d = q_s4[8] ? 8'd0 : 8'(pbm_pkg::PIX_MAX - q_s4[7:0]);
			end
			pbm_pkg::MODE_DIV: begin
				res_d = sat_s4 ? pbm_pkg::PIX_MAX : quo;
			end
			default: begin
				res_d = dir_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			m_s1  <= mask;
			i_s1  <= image;
			p1_s1 <= 16'(mask) * 16'(image);
			q1_s1 <= 16'(8'(pbm_pkg::PIX_MAX - mask)) * 16'(8'(pbm_pkg::PIX_MAX - image));
			ma_s1 <= 16'(17'(mask) * 17'(cfg.alpha));
			ia_s1 <= 16'(17'(image) * 17'(cfg.alpha));
		end
		if (en[2]) begin
			m_s2  <= m_s1;
			i_s2  <= i_s1;
			p1_s2 <= p1_s1;
			q1_s2 <= q1_s1;
			pa_s2 <= 24'(p1_s1) * 24'(cfg.alpha);
			ya_s2 <= 24'(16'(pbm_pkg::FULL_SCALE - ma_s1))
				* 24'(8'(pbm_pkg::PIX_MAX - i_s1));
			yb_s2 <= 24'(8'(pbm_pkg::PIX_MAX - m_s1))
				* 24'(16'(pbm_pkg::FULL_SCALE - ia_s1));
		end
		if (en[3]) begin
			n_s3   <= n_d;
			dir_s3 <= dir_d;
			sat_s3 <= (i_s2 >= m_s2);
		end
		if (en[4]) begin
			q_s4   <= recip_prod[pbm_pkg::RECIP_SHIFT +: 9];
			dir_s4 <= dir_s3;
			sat_s4 <= sat_s3;
		end
		if (en[5]) begin
			result_s5 <= res_d;
		end
	end

	`ifndef NO_ASSERTIONS
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && !res_ready))
		else $error("input blocked while a pipeline stage is empty");
	a_word_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && en[5]) |=> vld_s5)
		else $error("word lost between stage 4 and the output");
	a_recip_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (q_s4 <= 9'd256))
		else $error("reciprocal quotient out of range");
	`endif

endmodule

>>> rtl/pbm_apb_regs.sv
// APB register file holding the blend mode and the alpha strength.
`timescale 1ns / 1ps

module pbm_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pbm_pkg::ADDR_W-1:0]  paddr,
	input  logic [pbm_pkg::DATA_W-1:0]  pwdata,
	output logic [pbm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output pbm_pkg::pbm_cfg_t           cfg
);

	logic [pbm_pkg::MODE_W-1:0]  mode_q;
	logic [pbm_pkg::ALPHA_W-1:0] alpha_q;
	logic                        wr_en;

	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= pbm_pkg::MODE_RESET;
			alpha_q <= pbm_pkg::ALPHA_ONE;
		end else if (wr_en) begin
			unique case (paddr[2])
				pbm_pkg::REG_MODE: begin
					mode_q <= pwdata[pbm_pkg::MODE_W-1:0];
				end
				pbm_pkg::REG_ALPHA: begin
					alpha_q <= pwdata[pbm_pkg::ALPHA_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pbm_pkg::REG_MODE: begin
				prdata = {{(pbm_pkg::DATA_W-pbm_pkg::MODE_W){1'b0}}, mode_q};
			end
			pbm_pkg::REG_ALPHA: begin
				prdata = {{(pbm_pkg::DATA_W-pbm_pkg::ALPHA_W){1'b0}}, alpha_q};
			end
		endcase
	end

	// Alpha above one counts as one.
	assign cfg.mode  = mode_q;
	assign cfg.alpha = (alpha_q > pbm_pkg::ALPHA_ONE) ? pbm_pkg::ALPHA_ONE : alpha_q;

endmodule

>>> rtl/pbm_div.sv
// Four-stage restoring divider giving two quotient bits of 256*image/mask per stage.
`timescale 1ns / 1ps

module pbm_div (
	input  logic                       clk,
	input  logic [3:0]                 adv,
	input  logic [pbm_pkg::PIX_W-1:0]  dividend,
	input  logic [pbm_pkg::PIX_W-1:0]  divisor,
	output logic [pbm_pkg::PIX_W-1:0]  quotient
);

	localparam int STEPS = 2;

	logic [7:0] rem_s1, rem_s2, rem_s3;
	logic [7:0] quo_s1, quo_s2, quo_s3, quo_s4;
	logic [7:0] dvs_s1, dvs_s2, dvs_s3;
	logic [15:0] nx1, nx2, nx3, nx4;

	function automatic logic [15:0] div_two(input logic [7:0] r, input logic [7:0] q,
		input logic [7:0] d);
		logic [8:0] t;
		logic [7:0] rr;
		logic [7:0] qq;
		rr = r;
		qq = q;
		for (int k = 0; k < STEPS; k++) begin
			t = {rr, 1'b0};
			if (t >= {1'b0, d}) begin
				rr = 8'(t - {1'b0, d});
				qq = {qq[6:0], 1'b1};
			end else begin
				rr = t[7:0];
				qq = {qq[6:0], 1'b0};
			end
		end
		return {rr, qq};
	endfunction

	assign nx1 = div_two(dividend, 8'd0, divisor);
	assign nx2 = div_two(rem_s1, quo_s1, dvs_s1);
	assign nx3 = div_two(rem_s2, quo_s2, dvs_s2);
	assign nx4 = div_two(rem_s3, quo_s3, dvs_s3);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s1 <= nx1[15:8];
			quo_s1 <= nx1[7:0];
			dvs_s1 <= divisor;
		end
		if (adv[1]) begin
			rem_s2 <= nx2[15:8];
			quo_s2 <= nx2[7:0];
			dvs_s2 <= dvs_s1;
		end
		if (adv[2]) begin
			rem_s3 <= nx3[15:8];
			quo_s3 <= nx3[7:0];
			dvs_s3 <= dvs_s2;
		end
		if (adv[3]) begin
			quo_s4 <= nx4[7:0];
		end
	end

	assign quotient = quo_s4;

	`ifndef NO_ASSERTIONS
	a_rem_below_divisor: assert property (@(posedge clk)
		(dvs_s1 != 8'd0 && rem_s1 < dvs_s1 && adv[1]) |=> (rem_s2 < dvs_s2))
		else $error("divider remainder left its range");
	`endif

endmodule
